// ===== hdl/priority_sstf_disk_request_scheduler_assert.svh =====
// Assertion macros shared by the disk request scheduler RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef PRIORITY_SSTF_DISK_REQUEST_SCHEDULER_ASSERT_SVH
`define PRIORITY_SSTF_DISK_REQUEST_SCHEDULER_ASSERT_SVH
`ifndef SYNTHESIS
// Property that must hold in the same cycle.
`define PSDR_ASSERT_NOW(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Consequent that must hold in the cycle after the antecedent.
`define PSDR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define PSDR_ASSERT_NOW(lbl, clk, rstn, prop, msg)
`define PSDR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== hdl/psdr_pkg.sv =====
// Package of the disk request scheduler: beat types, status codes and
// register indexes. Depends on nothing.
package psdr_pkg;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    REG_POLICY  = 1'b0,
    REG_LATENCY = 1'b1
  } reg_idx_e;

  localparam logic REQ_ENQUEUE  = 1'b0;
  localparam logic REQ_DISPATCH = 1'b1;

  localparam logic [7:0] OFFSET_RESET_VAL = 8'd5;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  request_tag;
    logic [31:0] block_number;
    logic [2:0]  priority_level;
    logic        has_owner;
  } req_t;

  typedef struct packed {
    logic [1:0]  status_code;
    logic [7:0]  granted_tag;
    logic [31:0] granted_block;
    logic [32:0] seek_latency;
    logic [4:0]  pending_count;
  } rsp_t;

  // Payload of the running winner that travels down the cell chain.
  typedef struct packed {
    logic [7:0]  tag;
    logic [31:0] block;
    logic [31:0] seek_dist;
  } grant_t;

endpackage

// ===== hdl/psdr_cell.sv =====
// One table slot of the scheduler plus one stage of the winner chain.
// Depends on psdr_pkg.
module psdr_cell #(
  parameter int QUEUE_DEPTH = 16,
  parameter int LEVEL_BITS  = 3,
  parameter int CELL_IDX    = 0
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               policy_i,
  input  logic [31:0]                        head_i,
  input  logic                               ld_i,
  input  psdr_pkg::req_t                     ld_req_i,
  input  logic                               shift_i,
  input  logic                               nb_vld_i,
  input  logic [7:0]                         nb_tag_i,
  input  logic [31:0]                        nb_blk_i,
  input  logic [LEVEL_BITS-1:0]              nb_lvl_i,
  input  logic                               nb_own_i,
  output logic                               vld_o,
  output logic [7:0]                         tag_o,
  output logic [31:0]                        blk_o,
  output logic [LEVEL_BITS-1:0]              lvl_o,
  output logic                               own_o,
  input  logic                               bst_vld_i,
  input  logic                               bst_nown_i,
  input  logic [LEVEL_BITS-1:0]              bst_lvl_i,
  input  logic [$clog2(QUEUE_DEPTH)-1:0]     bst_idx_i,
  input  psdr_pkg::grant_t                   bst_gnt_i,
  output logic                               bst_vld_o,
  output logic                               bst_nown_o,
  output logic [LEVEL_BITS-1:0]              bst_lvl_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0]     bst_idx_o,
  output psdr_pkg::grant_t                   bst_gnt_o
);
  import psdr_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int KEY_W = 1 + LEVEL_BITS + 32;

  logic                  vld_q;
  logic [7:0]            tag_q;
  logic [31:0]           blk_q;
  logic [LEVEL_BITS-1:0] lvl_q;
  logic                  own_q;

  logic                  bst_vld_q;
  logic                  bst_nown_q;
  logic [LEVEL_BITS-1:0] bst_lvl_q;
  logic [IDX_W-1:0]      bst_idx_q;
  grant_t                bst_gnt_q;

  logic [32:0]           diff_bh;
  logic [32:0]           diff_hb;
  logic [31:0]           my_dist;
  logic [LEVEL_BITS-1:0] my_lvl;
  logic [KEY_W-1:0]      my_key;
  logic [KEY_W-1:0]      in_key;
  logic                  take;

  // Slot storage: closes the gap on a removal, loads on an append.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (shift_i) begin
      vld_q <= nb_vld_i;
    end else if (ld_i) begin
      vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      tag_q <= nb_tag_i;
      blk_q <= nb_blk_i;
      lvl_q <= nb_lvl_i;
      own_q <= nb_own_i;
    end else if (ld_i) begin
      tag_q <= ld_req_i.request_tag;
      blk_q <= ld_req_i.block_number;
      lvl_q <= LEVEL_BITS'(ld_req_i.priority_level);
      own_q <= ld_req_i.has_owner;
    end
  end

  assign vld_o = vld_q;
  assign tag_o = tag_q;
  assign blk_o = blk_q;
  assign lvl_o = lvl_q;
  assign own_o = own_q;

  // Sort key: unowned after owned, then level, then seek distance under SSTF.
  assign diff_bh = {1'b0, blk_q} - {1'b0, head_i};
  assign diff_hb = {1'b0, head_i} - {1'b0, blk_q};
  assign my_dist = diff_bh[32] ? diff_hb[31:0] : diff_bh[31:0];
  assign my_lvl  = own_q ? lvl_q : '0;
  assign my_key  = {~own_q, my_lvl, (policy_i ? my_dist : 32'd0)};
  assign in_key  = {bst_nown_i, bst_lvl_i, (policy_i ? bst_gnt_i.seek_dist : 32'd0)};
  // Strictly smaller wins, so equal keys keep the older entry upstream.
  assign take    = vld_q && (!bst_vld_i || (my_key < in_key));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bst_vld_q <= 1'b0;
    end else begin
      bst_vld_q <= bst_vld_i || vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      bst_nown_q          <= ~own_q;
      bst_lvl_q           <= my_lvl;
      bst_idx_q           <= IDX_W'(CELL_IDX);
      bst_gnt_q.tag       <= tag_q;
      bst_gnt_q.block     <= blk_q;
      bst_gnt_q.seek_dist <= my_dist;
    end else begin
      bst_nown_q <= bst_nown_i;
      bst_lvl_q  <= bst_lvl_i;
      bst_idx_q  <= bst_idx_i;
      bst_gnt_q  <= bst_gnt_i;
    end
  end

  assign bst_vld_o  = bst_vld_q;
  assign bst_nown_o = bst_nown_q;
  assign bst_lvl_o  = bst_lvl_q;
  assign bst_idx_o  = bst_idx_q;
  assign bst_gnt_o  = bst_gnt_q;

endmodule

// ===== hdl/priority_sstf_disk_request_scheduler.sv =====
// An enqueue, a full enqueue or an empty dispatch is answered in the cycle after it is accepted.
// A dispatch waits for the winner chain, which moves one cell per cycle, and then for
// a free output register; one item is in work at a time, so no new beat is accepted
// until the dispatch is answered. Reset (async, active low) empties the table, zeroes the head,
// selects first come first served and sets the latency offset to OFFSET_RESET_VAL.
// Top level of the disk request scheduler; depends on psdr_pkg, psdr_cell.
`include "priority_sstf_disk_request_scheduler_assert.svh"
module priority_sstf_disk_request_scheduler #(
  parameter int QUEUE_DEPTH = 16,
  parameter int LEVEL_BITS  = 3
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  psdr_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output psdr_pkg::rsp_t out_rsp_o,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import psdr_pkg::*;

  // The table is a row of cells, oldest request in cell 0. Each cell also
  // holds one register of the winner chain: the best candidate seen so far
  // enters cell 0 empty and picks up a better entry at each cell, one cell
  // per cycle. The table and head stay frozen while a dispatch is in flight;
  // the user must hold the policy then, as the block does not enforce it. The
  // last cell holds the true winner when the scan ends. Its index tells every
  // cell at or above it to take its younger neighbor's entry, closing the gap.

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  state_e     state_q;
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] count_q;
  logic [31:0] head_q;
  logic        out_vld_q;
  rsp_t        out_q;
  logic        policy_q;
  logic [7:0]  offset_q;

  logic out_free;
  logic in_acc;
  logic tbl_full;
  logic enq_ok;
  logic scan_done;
  logic out_set;

  // Cell row wiring; entry QUEUE_DEPTH of the chain arrays is the last cell's output.
  logic                  vld_w  [QUEUE_DEPTH];
  logic [7:0]            tag_w  [QUEUE_DEPTH];
  logic [31:0]           blk_w  [QUEUE_DEPTH];
  logic [LEVEL_BITS-1:0] lvl_w  [QUEUE_DEPTH];
  logic                  own_w  [QUEUE_DEPTH];
  logic                  bvld_w [QUEUE_DEPTH+1];
  logic                  bnown_w[QUEUE_DEPTH+1];
  logic [LEVEL_BITS-1:0] blvl_w [QUEUE_DEPTH+1];
  logic [IDX_W-1:0]      bidx_w [QUEUE_DEPTH+1];
  grant_t                bgnt_w [QUEUE_DEPTH+1];

  logic [IDX_W-1:0] pick;
  grant_t           win;

  assign out_free   = !out_vld_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign in_acc     = in_valid_i && in_ready_o;
  assign tbl_full   = (count_q == CNT_W'(QUEUE_DEPTH));
  assign enq_ok     = in_acc && (in_req_i.req_type == REQ_ENQUEUE) && !tbl_full;
  assign scan_done  = (state_q == S_SCAN) && (cnt_q == CNT_W'(QUEUE_DEPTH)) && out_free;

  // A result beat is loaded by every accepted beat except a dispatch that
  // starts a scan, and by the end of that scan.
  assign out_set = (in_acc && ((in_req_i.req_type == REQ_ENQUEUE) || (count_q == '0)))
                   || scan_done;

  assign pick = bidx_w[QUEUE_DEPTH];
  assign win  = bgnt_w[QUEUE_DEPTH];

  // The chain starts empty at cell 0.
  assign bvld_w[0]  = 1'b0;
  assign bnown_w[0] = 1'b0;
  assign blvl_w[0]  = '0;
  assign bidx_w[0]  = '0;
  assign bgnt_w[0]  = '0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                  nb_vld;
    logic [7:0]            nb_tag;
    logic [31:0]           nb_blk;
    logic [LEVEL_BITS-1:0] nb_lvl;
    logic                  nb_own;

    if (i + 1 < QUEUE_DEPTH) begin : g_nb
      assign nb_vld = vld_w[i+1];
      assign nb_tag = tag_w[i+1];
      assign nb_blk = blk_w[i+1];
      assign nb_lvl = lvl_w[i+1];
      assign nb_own = own_w[i+1];
    end else begin : g_end
      // The youngest cell empties when the row shifts.
      assign nb_vld = 1'b0;
      assign nb_tag = '0;
      assign nb_blk = '0;
      assign nb_lvl = '0;
      assign nb_own = 1'b0;
    end

    psdr_cell #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .LEVEL_BITS (LEVEL_BITS),
      .CELL_IDX   (i)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .policy_i  (policy_q),
      .head_i    (head_q),
      .ld_i      (enq_ok && (count_q == CNT_W'(i))),
      .ld_req_i  (in_req_i),
      .shift_i   (scan_done && (IDX_W'(i) >= pick)),
      .nb_vld_i  (nb_vld),
      .nb_tag_i  (nb_tag),
      .nb_blk_i  (nb_blk),
      .nb_lvl_i  (nb_lvl),
      .nb_own_i  (nb_own),
      .vld_o     (vld_w[i]),
      .tag_o     (tag_w[i]),
      .blk_o     (blk_w[i]),
      .lvl_o     (lvl_w[i]),
      .own_o     (own_w[i]),
      .bst_vld_i (bvld_w[i]),
      .bst_nown_i(bnown_w[i]),
      .bst_lvl_i (blvl_w[i]),
      .bst_idx_i (bidx_w[i]),
      .bst_gnt_i (bgnt_w[i]),
      .bst_vld_o (bvld_w[i+1]),
      .bst_nown_o(bnown_w[i+1]),
      .bst_lvl_o (blvl_w[i+1]),
      .bst_idx_o (bidx_w[i+1]),
      .bst_gnt_o (bgnt_w[i+1])
    );
  end

  // Control, table fill count, head position and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      count_q   <= '0;
      head_q    <= '0;
      out_vld_q <= 1'b0;
      out_q     <= '0;
    end else begin
      if (out_set) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            out_q.granted_tag   <= '0;
            out_q.granted_block <= '0;
            out_q.seek_latency  <= '0;
            if (in_req_i.req_type == REQ_ENQUEUE) begin
              if (tbl_full) begin
                out_q.status_code   <= STATUS_FULL;
                out_q.pending_count <= 5'(count_q);
              end else begin
                out_q.status_code   <= STATUS_OK;
                out_q.pending_count <= 5'(count_q + 1'b1);
                count_q             <= count_q + 1'b1;
              end
            end else if (count_q == '0) begin
              out_q.status_code   <= STATUS_EMPTY;
              out_q.pending_count <= 5'(count_q);
            end else begin
              state_q <= S_SCAN;
              cnt_q   <= '0;
            end
          end
        end
        S_SCAN: begin
          if (cnt_q != CNT_W'(QUEUE_DEPTH)) begin
            cnt_q <= cnt_q + 1'b1;
          end else if (out_free) begin
            out_q.status_code   <= STATUS_OK;
            out_q.granted_tag   <= win.tag;
            out_q.granted_block <= win.block;
            out_q.seek_latency  <= {1'b0, win.seek_dist} + 33'(offset_q);
            out_q.pending_count <= 5'(count_q - 1'b1);
            count_q             <= count_q - 1'b1;
            head_q              <= win.block;
            state_q             <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_q;

  // Configuration registers; only the register index bit of the address is decoded.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= 1'b0;
      offset_q <= OFFSET_RESET_VAL;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx_e'(paddr[2]))
        REG_POLICY:  policy_q <= pwdata[0];
        REG_LATENCY: offset_q <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[2]))
      REG_POLICY:  prdata = {31'd0, policy_q};
      REG_LATENCY: prdata = {24'd0, offset_q};
    endcase
  end

  assign pready = 1'b1;

  // The fill count never passes the table depth.
  `PSDR_ASSERT_NOW(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(QUEUE_DEPTH), "fill count overflow")
  // A finished scan always carries a winner from the chain.
  `PSDR_ASSERT_NOW(a_win_valid, clk_i, rst_ni, !scan_done || bvld_w[QUEUE_DEPTH], "no winner at dispatch")
  // A dispatch leaves one entry fewer.
  `PSDR_ASSERT_NEXT(a_disp_count, clk_i, rst_ni, scan_done, count_q == $past(count_q) - 1'b1, "dispatch count")
  // An accepted append adds one entry.
  `PSDR_ASSERT_NEXT(a_enq_count, clk_i, rst_ni, enq_ok, count_q == $past(count_q) + 1'b1, "enqueue count")
  // The head moves only when a dispatch completes.
  `PSDR_ASSERT_NEXT(a_head_hold, clk_i, rst_ni, !scan_done, $stable(head_q), "head moved")

endmodule
